// File: src/lsws_pkg.sv
// lsws_pkg.sv: shared types, codes and defaults for the strip/window streamer
`timescale 1ns / 1ps

package lsws_pkg;

    // default geometry
    localparam int DEF_PANEL_WIDTH  = 240;
    localparam int DEF_PANEL_HEIGHT = 135;
    localparam int DEF_STRIP_ROWS   = 8;

    // configuration register reset values
    localparam logic [15:0] COLUMN_OFFSET_RST = 16'd40;
    localparam logic [15:0] ROW_OFFSET_RST    = 16'd53;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_OFFSET = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_OFFSET    = 2'd1;

    // panel commands
    localparam logic [7:0] CMD_COLUMN_SET   = 8'h2a;
    localparam logic [7:0] CMD_ROW_SET      = 8'h2b;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2c;

    // result kind and data/command flag
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam logic DC_COMMAND  = 1'b0;
    localparam logic DC_DATA     = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_BUSY    = 2'd2,
        STATUS_STRAY   = 2'd3
    } status_t;

    // what the emitter has to send for one transaction
    typedef enum logic [1:0] {
        JOB_STATUS = 2'd0,
        JOB_PIXEL  = 2'd1,
        JOB_WINDOW = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   jkind;
        status_t     code;
        logic [15:0] pixel;
        logic [15:0] x0;
        logic [15:0] x1;
        logic [15:0] y0;
        logic [15:0] y1;
    } job_t;

endpackage

// File: src/lsws_ctrl.sv
// lsws_ctrl.sv: request checking, window pointer tracking and job decode
`timescale 1ns / 1ps

module lsws_ctrl #(
    parameter int PANEL_WIDTH  = lsws_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = lsws_pkg::DEF_PANEL_HEIGHT,
    parameter int STRIP_ROWS   = lsws_pkg::DEF_STRIP_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             func,
    input  logic [8:0]                       left_col,
    input  logic [7:0]                       top_row,
    input  logic [8:0]                       width_cols,
    input  logic [3:0]                       height_rows,
    input  logic [15:0]                      pixel_word,
    input  logic                             cfg_write,
    input  logic [lsws_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data,
    output lsws_pkg::job_t                   job
);
    import lsws_pkg::*;

    localparam int PL_W = $clog2(PANEL_WIDTH * STRIP_ROWS + 1);

    logic [15:0]     column_offset_reg;
    logic [15:0]     row_offset_reg;
    logic            pointer_valid_reg, pointer_valid_next;
    logic [7:0]      pointer_row_reg, pointer_row_next;
    logic [PL_W-1:0] pixels_left_reg, pixels_left_next;

    logic            busy;
    logic            invalid;
    logic            strip;
    logic            need_window;
    logic [9:0]      x_end;
    logic [8:0]      y_end;
    logic [12:0]     pix_count;
    logic [15:0]     x0, y0;

    // bounds and path checks
    always_comb
    begin
        busy      = (pixels_left_reg != '0);
        x_end     = {1'b0, left_col} + {1'b0, width_cols};
        y_end     = {1'b0, top_row} + {5'b0, height_rows};
        invalid   = (width_cols == '0) || (x_end > 10'(PANEL_WIDTH)) ||
                    (height_rows == '0) || (height_rows > 4'(STRIP_ROWS)) ||
                    (y_end > 9'(PANEL_HEIGHT));
        strip     = (width_cols == 9'(PANEL_WIDTH));
        need_window = !strip || !pointer_valid_reg || (pointer_row_reg != top_row);
        pix_count = {4'b0, width_cols} * {9'b0, height_rows};
        x0        = column_offset_reg + {7'b0, left_col};
        y0        = row_offset_reg + {8'b0, top_row};
    end

    // job decode and next state
    always_comb
    begin
        job.jkind = JOB_STATUS;
        job.code  = STATUS_OK;
        job.pixel = pixel_word;
        job.x0    = x0;
        job.x1    = x0 + {7'b0, width_cols} - 16'd1;
        job.y0    = y0;
        job.y1    = strip ? (row_offset_reg + 16'(PANEL_HEIGHT - 1))
                          : (y0 + {12'b0, height_rows} - 16'd1);
        pointer_valid_next = pointer_valid_reg;
        pointer_row_next   = pointer_row_reg;
        pixels_left_next   = pixels_left_reg;
        if (func)
        begin
            if (busy)
            begin
                job.jkind        = JOB_PIXEL;
                pixels_left_next = pixels_left_reg - PL_W'(1);
            end
            else
            begin
                job.code = STATUS_STRAY;
            end
        end
        else if (busy)
        begin
            job.code = STATUS_BUSY;
        end
        else if (invalid)
        begin
            job.code = STATUS_INVALID;
        end
        else
        begin
            if (need_window)
            begin
                job.jkind = JOB_WINDOW;
            end
            pixels_left_next = PL_W'(pix_count);
            if (strip && (y_end < 9'(PANEL_HEIGHT)))
            begin
                pointer_valid_next = 1'b1;
                pointer_row_next   = y_end[7:0];
            end
            else
            begin
                pointer_valid_next = 1'b0;
            end
        end
    end

    // session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_valid_reg <= 1'b0;
            pointer_row_reg   <= '0;
            pixels_left_reg   <= '0;
        end
        else if (accept)
        begin
            pointer_valid_reg <= pointer_valid_next;
            pointer_row_reg   <= pointer_row_next;
            pixels_left_reg   <= pixels_left_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_offset_reg <= COLUMN_OFFSET_RST;
            row_offset_reg    <= ROW_OFFSET_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_COLUMN_OFFSET: column_offset_reg <= cfg_data;
                REG_ROW_OFFSET:    row_offset_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

endmodule

// File: src/lsws_emit.sv
// lsws_emit.sv: job slot and output register that serialize results
`timescale 1ns / 1ps

module lsws_emit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_load,
    input  lsws_pkg::job_t job_in,
    output logic           job_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           kind,
    output logic [7:0]     wire_byte,
    output logic           dc_flag,
    output logic [1:0]     status,
    output logic           last
);
    import lsws_pkg::*;

    localparam logic [3:0] PIXEL_LAST  = 4'd1;

    job_t       job_reg;
    logic       job_valid_reg;
    logic [3:0] idx_reg, idx_next;
    logic       out_valid_reg;
    logic       kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic       dc_reg, dc_next;
    logic [1:0] status_reg, status_next;
    logic       last_reg, last_next;
    logic       load;

    // pick the result at the current index of the job
    always_comb
    begin
        kind_next   = KIND_BYTE;
        byte_next   = '0;
        dc_next     = DC_DATA;
        status_next = STATUS_OK;
        last_next   = 1'b0;
        case (job_reg.jkind)
            JOB_PIXEL:
            begin
                byte_next = (idx_reg == '0) ? job_reg.pixel[15:8] : job_reg.pixel[7:0];
                last_next = (idx_reg == PIXEL_LAST);
            end
            JOB_WINDOW:
            begin
                case (idx_reg)
                    4'd0:
                    begin
                        byte_next = CMD_COLUMN_SET;
                        dc_next   = DC_COMMAND;
                    end
                    4'd1:    byte_next = job_reg.x0[15:8];
                    4'd2:    byte_next = job_reg.x0[7:0];
                    4'd3:    byte_next = job_reg.x1[15:8];
                    4'd4:    byte_next = job_reg.x1[7:0];
                    4'd5:
                    begin
                        byte_next = CMD_ROW_SET;
                        dc_next   = DC_COMMAND;
                    end
                    4'd6:    byte_next = job_reg.y0[15:8];
                    4'd7:    byte_next = job_reg.y0[7:0];
                    4'd8:    byte_next = job_reg.y1[15:8];
                    4'd9:    byte_next = job_reg.y1[7:0];
                    4'd10:
                    begin
                        byte_next = CMD_MEMORY_WRITE;
                        dc_next   = DC_COMMAND;
                    end
                    default:
                    begin
                        kind_next = KIND_STATUS;
                        dc_next   = DC_COMMAND;
                        last_next = 1'b1;
                    end
                endcase
            end
            default:
            begin
                kind_next   = KIND_STATUS;
                dc_next     = DC_COMMAND;
                status_next = job_reg.code;
                last_next   = 1'b1;
            end
        endcase
    end

    // advance when the output register is free or being drained
    assign load      = job_valid_reg && (!out_valid_reg || out_ready);
    assign job_ready = !job_valid_reg || (load && last_next);
    assign idx_next  = idx_reg + 4'd1;

    // job slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (job_load)
        begin
            job_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            job_valid_reg <= !last_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job_in;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_next;
            byte_reg   <= byte_next;
            dc_reg     <= dc_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign wire_byte = byte_reg;
    assign dc_flag   = dc_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

// File: src/lcd_strip_window_streamer_core.sv
// lcd_strip_window_streamer_core.sv: top level of the strip/window streamer
`timescale 1ns / 1ps

// Input channel (in_valid/in_ready) takes draw requests (func 0) and pixel
// words (func 1). Output channel (out_valid/out_ready) delivers one result
// per transaction: a panel byte with its command/data flag, or a status
// report; last marks the final result of each input transaction.
// Window opening yields 11 bytes then a status (12 results), a pixel yields
// two bytes high first, every other input yields one status result.
// An input is held in the job slot; its results are registered in the output register.
// Throughput: one result per cycle from the output register while the receiver
// does not stall. An input holds the single job slot in front of the output
// register until its last result is loaded, which sets the input rate; the
// next input is taken in the cycle its predecessor's last result is loaded.
// Configuration port (cfg_valid/cfg_ready) is always ready; index 0 writes
// the column offset, index 1 the row offset, others are ignored.
// Reset clears the session (no open window pointer, no pixels pending) and
// loads offsets 40 and 53. A receiver stall holds the output register and,
// once the job slot is full, drops in_ready.
module lcd_strip_window_streamer_core #(
    parameter int PANEL_WIDTH  = lsws_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = lsws_pkg::DEF_PANEL_HEIGHT,
    parameter int STRIP_ROWS   = lsws_pkg::DEF_STRIP_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             func,
    input  logic [8:0]                       left_col,
    input  logic [7:0]                       top_row,
    input  logic [8:0]                       width_cols,
    input  logic [3:0]                       height_rows,
    input  logic [15:0]                      pixel_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             kind,
    output logic [7:0]                       wire_byte,
    output logic                             dc_flag,
    output logic [1:0]                       status,
    output logic                             last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lsws_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data
);
    import lsws_pkg::*;

    job_t job;
    logic accept;

    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // decode and session state
    lsws_ctrl #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .STRIP_ROWS   (STRIP_ROWS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .func        (func),
        .left_col    (left_col),
        .top_row     (top_row),
        .width_cols  (width_cols),
        .height_rows (height_rows),
        .pixel_word  (pixel_word),
        .cfg_write   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .job         (job)
    );

    // result serializer
    lsws_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_load  (accept),
        .job_in    (job),
        .job_ready (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .wire_byte (wire_byte),
        .dc_flag   (dc_flag),
        .status    (status),
        .last      (last)
    );

endmodule

// File: src/lsws_checker.sv
// lsws_checker.sv: port-level assertions for the streamer and their bind
`timescale 1ns / 1ps

module lsws_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       kind,
    input logic [7:0] wire_byte,
    input logic       dc_flag,
    input logic [1:0] status,
    input logic       last
);
    import lsws_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wire_byte) &&
        $stable(kind) && $stable(dc_flag) && $stable(status) && $stable(last))
        else $error("stalled result changed");

    // a status report ends its transaction and carries no panel byte
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_STATUS) |->
        last && (wire_byte == 8'd0) && (dc_flag == DC_COMMAND))
        else $error("malformed status report");

    // panel bytes report accepted status
    a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_BYTE) |-> (status == STATUS_OK))
        else $error("panel byte with nonzero status");

    // a command byte is always followed by more results of the same input
    a_cmd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_BYTE) && (dc_flag == DC_COMMAND) |-> !last)
        else $error("command byte marked last");

endmodule

bind lcd_strip_window_streamer_core lsws_checker u_lsws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .wire_byte (wire_byte),
    .dc_flag   (dc_flag),
    .status    (status),
    .last      (last)
);
